// File: src/ldcf_pkg.sv
// Package for the lens driver command framer: frame tag characters, the
// microcode control word, the microprogram ROM and the CRC-16/ARC byte update.
// No dependencies; imported by lens_driver_command_framer, ldcf_checker and tb.
`default_nettype none

package ldcf_pkg;

    // Widths fixed by the command fields
    localparam int OP_W    = 2;
    localparam int CUR_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int FREQ_W  = 32;
    localparam int MAG_W   = CUR_W + 1;
    localparam int PROD_W  = MAG_W + GAIN_W;
    localparam int SHIFT   = 22;
    localparam int Q_W     = PROD_W - SHIFT + 1;
    localparam int PC_W    = 6;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd916663;
    localparam logic [15:0]       CRC_POLY   = 16'hA001;

    // Command opcodes
    localparam logic [OP_W-1:0] OP_SINE   = 2'd0;
    localparam logic [OP_W-1:0] OP_CUR    = 2'd1;
    localparam logic [OP_W-1:0] OP_MINMAX = 2'd2;
    localparam logic [OP_W-1:0] OP_FREQ   = 2'd3;

    // ASCII tag characters
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_W = 8'h77;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_0 = 8'h00;

    // Program entry points
    localparam logic [PC_W-1:0] PC_SINE   = 6'd0;
    localparam logic [PC_W-1:0] PC_CUR    = 6'd6;
    localparam logic [PC_W-1:0] PC_MINMAX = 6'd14;
    localparam logic [PC_W-1:0] PC_FREQ   = 6'd38;
    localparam logic [PC_W-1:0] PC_REJ    = 6'd49;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // Byte source select
    typedef enum logic [3:0] {
        SRC_LIT,
        SRC_CODEH,
        SRC_CODEL,
        SRC_CRCL,
        SRC_CRCH,
        SRC_FRQ3,
        SRC_FRQ2,
        SRC_FRQ1,
        SRC_FRQ0
    } src_t;

    // Multiplier operand select
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_A,
        MUL_B
    } mul_t;

    typedef struct packed {
        logic            emit;
        src_t            src;
        logic [7:0]      lit;
        logic            crc_upd;
        logic            crc_clr;
        logic            last;
        logic            rej;
        logic            set_sine;
        mul_t            mul;
        logic            code_ld;
        logic            jmp_nosine;
        logic [PC_W-1:0] target;
        logic            done;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        emit: 1'b0, src: SRC_LIT, lit: 8'h00, crc_upd: 1'b0, crc_clr: 1'b0,
        last: 1'b0, rej: 1'b0, set_sine: 1'b0, mul: MUL_NONE, code_ld: 1'b0,
        jmp_nosine: 1'b0, target: '0, done: 1'b0
    };

    // Body byte from a literal; clr marks the first byte of a frame
    function automatic ctrl_t u_chr(input logic [7:0] ch, input logic clr);
        ctrl_t c;
        c         = CTRL_NOP;
        c.emit    = 1'b1;
        c.src     = SRC_LIT;
        c.lit     = ch;
        c.crc_upd = 1'b1;
        c.crc_clr = clr;
        return c;
    endfunction

    // Byte from a datapath source; CRC bytes do not feed the CRC
    function automatic ctrl_t u_src(input src_t s);
        ctrl_t c;
        c         = CTRL_NOP;
        c.emit    = 1'b1;
        c.src     = s;
        c.crc_upd = (s != SRC_CRCL) && (s != SRC_CRCH);
        return c;
    endfunction

    // Final CRC byte of a command
    function automatic ctrl_t u_crch_end(input logic sine);
        ctrl_t c;
        c          = u_src(SRC_CRCH);
        c.last     = 1'b1;
        c.done     = 1'b1;
        c.set_sine = sine;
        return c;
    endfunction

    function automatic ctrl_t u_mul(input mul_t m, input logic chk);
        ctrl_t c;
        c            = CTRL_NOP;
        c.mul        = m;
        c.jmp_nosine = chk;
        c.target     = PC_REJ;
        return c;
    endfunction

    function automatic ctrl_t u_code();
        ctrl_t c;
        c         = CTRL_NOP;
        c.code_ld = 1'b1;
        return c;
    endfunction

    // Microprogram ROM
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = CTRL_NOP;
        case (pc)
            // sine mode frame
            6'd0:  c = u_chr(CH_M, 1'b1);
            6'd1:  c = u_chr(CH_W, 1'b0);
            6'd2:  c = u_chr(CH_S, 1'b0);
            6'd3:  c = u_chr(CH_A, 1'b0);
            6'd4:  c = u_src(SRC_CRCL);
            6'd5:  c = u_crch_end(1'b1);
            // current frame
            6'd6:  c = u_mul(MUL_A, 1'b0);
            6'd7:  c = u_code();
            6'd8:  c = u_chr(CH_A, 1'b1);
            6'd9:  c = u_chr(CH_W, 1'b0);
            6'd10: c = u_src(SRC_CODEH);
            6'd11: c = u_src(SRC_CODEL);
            6'd12: c = u_src(SRC_CRCL);
            6'd13: c = u_crch_end(1'b0);
            // min/max: lower frame, then upper frame
            6'd14: c = u_mul(MUL_A, 1'b1);
            6'd15: c = u_code();
            6'd16: c = u_chr(CH_P, 1'b1);
            6'd17: c = u_chr(CH_W, 1'b0);
            6'd18: c = u_chr(CH_L, 1'b0);
            6'd19: c = u_chr(CH_A, 1'b0);
            6'd20: c = u_src(SRC_CODEH);
            6'd21: c = u_src(SRC_CODEL);
            6'd22: c = u_chr(CH_0, 1'b0);
            6'd23: c = u_chr(CH_0, 1'b0);
            6'd24: c = u_src(SRC_CRCL);
            6'd25: c = u_src(SRC_CRCH);
            6'd26: c = u_mul(MUL_B, 1'b0);
            6'd27: c = u_code();
            6'd28: c = u_chr(CH_P, 1'b1);
            6'd29: c = u_chr(CH_W, 1'b0);
            6'd30: c = u_chr(CH_U, 1'b0);
            6'd31: c = u_chr(CH_A, 1'b0);
            6'd32: c = u_src(SRC_CODEH);
            6'd33: c = u_src(SRC_CODEL);
            6'd34: c = u_chr(CH_0, 1'b0);
            6'd35: c = u_chr(CH_0, 1'b0);
            6'd36: c = u_src(SRC_CRCL);
            6'd37: c = u_crch_end(1'b0);
            // frequency frame
            6'd38: c = u_mul(MUL_NONE, 1'b1);
            6'd39: c = u_chr(CH_P, 1'b1);
            6'd40: c = u_chr(CH_W, 1'b0);
            6'd41: c = u_chr(CH_F, 1'b0);
            6'd42: c = u_chr(CH_A, 1'b0);
            6'd43: c = u_src(SRC_FRQ3);
            6'd44: c = u_src(SRC_FRQ2);
            6'd45: c = u_src(SRC_FRQ1);
            6'd46: c = u_src(SRC_FRQ0);
            6'd47: c = u_src(SRC_CRCL);
            6'd48: c = u_crch_end(1'b0);
            // refused command: one zero byte
            6'd49:
            begin
                c      = u_chr(CH_0, 1'b0);
                c.last = 1'b1;
                c.rej  = 1'b1;
                c.done = 1'b1;
            end
            default:
            begin
                c      = CTRL_NOP;
                c.done = 1'b1;
            end
        endcase
        return c;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [OP_W-1:0] op);
        logic [PC_W-1:0] pc;
        case (op)
            OP_SINE:   pc = PC_SINE;
            OP_CUR:    pc = PC_CUR;
            OP_MINMAX: pc = PC_MINMAX;
            OP_FREQ:   pc = PC_FREQ;
            default:   pc = PC_REJ;
        endcase
        return pc;
    endfunction

    // CRC-16/ARC, reflected, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/lens_driver_command_framer.sv
// Lens driver command framer top level: microcoded sequencer, gain multiplier,
// CRC-16/ARC and the output byte register. Depends on ldcf_pkg.
//
// Usage: a command is a transfer on in_valid/in_ready carrying opcode,
// current_first, current_second and freq_millihertz. The block turns it into
// frame bytes, one transfer each on out_valid/out_ready, with last_byte set
// on the final byte and rejected set on the single zero byte of a refused
// min/max or frequency command (sine mode off).
// One command is handled at a time: in_ready is high only while the sequencer
// is idle. Byte steps wait for room in the output register. The microprogram
// of a command has 6 (sine), 8 (current), 24 (min/max), 11 (frequency) or
// 2 (refused) steps. The sine program opens with its first byte; frequency
// and refused commands first pass a sine mode check step, current and min/max
// a multiply step and a code step before the frame of each code.
// A stalled receiver holds the step counter at a byte step; no byte is lost
// or repeated.
// cfg_wr_en writes current_gain; change it only while idle.
// Reset clears the sequencer, the output valid flag and the sine mode flag,
// and loads current_gain with 916663.
`default_nettype none

module lens_driver_command_framer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ldcf_pkg::OP_W-1:0]    opcode,
    input  wire logic signed [ldcf_pkg::CUR_W-1:0] current_first,
    input  wire logic signed [ldcf_pkg::CUR_W-1:0] current_second,
    input  wire logic [ldcf_pkg::FREQ_W-1:0]  freq_millihertz,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        tx_byte,
    output logic                              last_byte,
    output logic                              rejected,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ldcf_pkg::GAIN_W-1:0]  cfg_wr_data
);
    import ldcf_pkg::*;

    seq_state_t                state_reg, state_next;
    logic [PC_W-1:0]           pc_reg, pc_next;
    logic                      sine_reg, sine_next;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [CUR_W-1:0]   a_reg, b_reg;
    logic [FREQ_W-1:0]         freq_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      neg_reg;
    logic [15:0]               code_reg;
    logic [15:0]               crc_reg, crc_next;
    logic                      out_valid_reg, out_valid_next;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg, out_rej_reg;

    ctrl_t                     ctrl;
    logic                      room;
    logic                      go;
    logic                      accept;
    logic                      swap;
    logic [7:0]                byte_sel;
    logic signed [CUR_W-1:0]   mul_op;
    logic                      mul_neg;
    logic [MAG_W-1:0]          mul_mag;
    logic [Q_W-1:0]            q_val;
    logic [15:0]               code_val;

    assign ctrl      = ucode_rom(pc_reg);
    assign room      = !out_valid_reg || out_ready;
    assign go        = (state_reg == SEQ_RUN) && (!ctrl.emit || room);
    assign in_ready  = (state_reg == SEQ_IDLE);
    assign accept    = in_valid && in_ready;
    assign swap      = (opcode == OP_MINMAX) && (current_second > current_first);

    assign out_valid = out_valid_reg;
    assign tx_byte   = out_byte_reg;
    assign last_byte = out_last_reg;
    assign rejected  = out_rej_reg;

    // Byte source mux
    always_comb
    begin
        case (ctrl.src)
            SRC_LIT:   byte_sel = ctrl.lit;
            SRC_CODEH: byte_sel = code_reg[15:8];
            SRC_CODEL: byte_sel = code_reg[7:0];
            SRC_CRCL:  byte_sel = crc_reg[7:0];
            SRC_CRCH:  byte_sel = crc_reg[15:8];
            SRC_FRQ3:  byte_sel = freq_reg[31:24];
            SRC_FRQ2:  byte_sel = freq_reg[23:16];
            SRC_FRQ1:  byte_sel = freq_reg[15:8];
            SRC_FRQ0:  byte_sel = freq_reg[7:0];
            default:   byte_sel = 8'h00;
        endcase
    end

    // Multiplier operand: magnitude and sign
    assign mul_op  = (ctrl.mul == MUL_B) ? b_reg : a_reg;
    assign mul_neg = mul_op[CUR_W-1];
    assign mul_mag = mul_neg ? (MAG_W'(0) - {mul_op[CUR_W-1], mul_op})
                             : {1'b0, mul_op};

    // Round half away from zero, then saturate
    assign q_val = {1'b0, prod_reg[PROD_W-1:SHIFT]} + Q_W'(prod_reg[SHIFT-1]);
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_val > Q_W'(32768))
                code_val = 16'h8000;
            else
                code_val = 16'(Q_W'(0) - q_val);
        end
        else
        begin
            if (q_val > Q_W'(32767))
                code_val = 16'h7FFF;
            else
                code_val = q_val[15:0];
        end
    end

    // CRC update on body bytes
    always_comb
    begin
        crc_next = crc_reg;
        if (go && ctrl.emit && ctrl.crc_upd)
            crc_next = crc_byte(ctrl.crc_clr ? 16'h0000 : crc_reg, byte_sel);
    end

    // Sequencer: state, step counter, jumps
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        sine_next  = sine_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SEQ_RUN;
                    pc_next    = entry_pc(opcode);
                end
            end
            SEQ_RUN:
            begin
                if (go)
                begin
                    if (ctrl.set_sine)
                        sine_next = 1'b1;
                    if (ctrl.done)
                        state_next = SEQ_IDLE;
                    else if (ctrl.jmp_nosine && !sine_reg)
                        pc_next = ctrl.target;
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go && ctrl.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            pc_reg        <= '0;
            sine_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            gain_reg      <= GAIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            sine_reg      <= sine_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                gain_reg <= cfg_wr_data;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= swap ? current_first : ((opcode == OP_MINMAX) ? current_second
                                                                     : current_first);
            b_reg    <= swap ? current_second : current_first;
            freq_reg <= freq_millihertz;
        end
        if (go && (ctrl.mul != MUL_NONE))
        begin
            prod_reg <= PROD_W'(mul_mag) * PROD_W'(gain_reg);
            neg_reg  <= mul_neg;
        end
        if (go && ctrl.code_ld)
            code_reg <= code_val;
        crc_reg <= crc_next;
        if (go && ctrl.emit)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= ctrl.last;
            out_rej_reg  <= ctrl.rej;
        end
    end

endmodule

`default_nettype wire

// File: verif/ldcf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for lens_driver_command_framer. It watches the command, byte and
// gain-write ports, predicts every frame byte and compares them in order.
// Depends on ldcf_pkg for widths, opcodes and tag characters.
module ldcf_checker
    import ldcf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [CUR_W-1:0]  current_first,
    input  logic signed [CUR_W-1:0]  current_second,
    input  logic [FREQ_W-1:0]        freq_millihertz,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [7:0]               tx_byte,
    input  logic                     last_byte,
    input  logic                     rejected,
    input  logic                     cfg_wr_en,
    input  logic [GAIN_W-1:0]        cfg_wr_data,
    output int                       fail_count,
    output int                       pending
);

    typedef struct {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       rejected;
    } frame_byte_t;

    frame_byte_t       byte_q[$];
    frame_byte_t       want;
    logic [GAIN_W-1:0] gain;
    logic              sine_on;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Driver code: current times gain over 2^22, round half away, saturate
    function automatic logic [15:0] drive_code(input logic signed [15:0] cur,
                                               input logic [GAIN_W-1:0] g);
        longint mag;
        longint q;
        mag = cur;
        if (mag < 0)
            mag = -mag;
        q = (mag * longint'({40'd0, g}) + (longint'(1) << 21)) >>> 22;
        if (cur < 0)
        begin
            if (q > 32768)
                q = 32768;
            return 16'(-q);
        end
        if (q > 32767)
            q = 32767;
        return 16'(q);
    endfunction

    // CRC-16/ARC, bit-serial, LSB first
    function automatic logic [15:0] arc_crc16(input logic [0:7][7:0] body, input int len);
        logic [15:0] crc;
        logic        fb;
        crc = '0;
        for (int i = 0; i < len; i++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                fb  = crc[0] ^ body[i][b];
                crc = crc >> 1;
                if (fb)
                    crc = crc ^ 16'hA001;
            end
        end
        return crc;
    endfunction

    // Append one expected byte at the tail of the queue
    function automatic void queue_byte(input logic [7:0] b, input logic lst,
                                       input logic rej);
        frame_byte_t fb;
        fb.tx_byte   = b;
        fb.last_byte = lst;
        fb.rejected  = rej;
        byte_q.insert(byte_q.size(), fb);
    endfunction

    // Queue one frame: body bytes, then CRC low and high
    task automatic push_frame(input logic [0:7][7:0] body, input int len,
                              input logic ends_cmd);
        logic [15:0] crc;
        crc = arc_crc16(body, len);
        for (int i = 0; i < len; i++)
            queue_byte(body[i], 1'b0, 1'b0);
        queue_byte(crc[7:0], 1'b0, 1'b0);
        queue_byte(crc[15:8], ends_cmd, 1'b0);
    endtask

    task automatic predict_cmd(input logic [OP_W-1:0] op,
                               input logic signed [15:0] a,
                               input logic signed [15:0] b,
                               input logic [31:0] f);
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        if ((op == OP_MINMAX || op == OP_FREQ) && !sine_on)
        begin
            queue_byte(8'h00, 1'b1, 1'b1);
            return;
        end
        case (op)
            OP_SINE:
            begin
                push_frame({CH_M, CH_W, CH_S, CH_A, 32'h0}, 4, 1'b1);
                sine_on = 1'b1;
            end
            OP_CUR:
                push_frame({CH_A, CH_W, drive_code(a, gain), 32'h0}, 4, 1'b1);
            OP_MINMAX:
            begin
                // lower bound always goes in the L frame
                hi = (b > a) ? b : a;
                lo = (b > a) ? a : b;
                push_frame({CH_P, CH_W, CH_L, CH_A, drive_code(lo, gain), 16'h0}, 8, 1'b0);
                push_frame({CH_P, CH_W, CH_U, CH_A, drive_code(hi, gain), 16'h0}, 8, 1'b1);
            end
            default:
                push_frame({CH_P, CH_W, CH_F, CH_A, f}, 8, 1'b1);
        endcase
    endtask

    // Per edge: gain write, byte compare, then command prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_q.delete();
            gain    = GAIN_RESET;
            sine_on = 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                gain = cfg_wr_data;

            if (out_valid && out_ready)
            begin
                if (byte_q.size() == 0)
                begin
                    $error("byte transfer %02h with nothing expected", tx_byte);
                    fail_count++;
                end
                else
                begin
                    want = byte_q.pop_front();
                    if (tx_byte !== want.tx_byte)
                    begin
                        $error("tx_byte: expected %02h, actual %02h", want.tx_byte, tx_byte);
                        fail_count++;
                    end
                    if (last_byte !== want.last_byte)
                    begin
                        $error("last_byte: expected %0b, actual %0b", want.last_byte, last_byte);
                        fail_count++;
                    end
                    if (rejected !== want.rejected)
                    begin
                        $error("rejected: expected %0b, actual %0b", want.rejected, rejected);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                predict_cmd(opcode, current_first, current_second, freq_millihertz);
        end
        pending = byte_q.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for lens_driver_command_framer: clock, reset, command and
// gain-write stimulus, receiver back-pressure and the verdict.
// Depends on ldcf_pkg, lens_driver_command_framer and ldcf_checker.
module tb;
    import ldcf_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 13;
    localparam int SQUEEZE_CYCLES  = 400;

    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    in_valid        = 1'b0;
    logic [OP_W-1:0]         opcode          = OP_SINE;
    logic signed [CUR_W-1:0] current_first   = '0;
    logic signed [CUR_W-1:0] current_second  = '0;
    logic [FREQ_W-1:0]       freq_millihertz = '0;
    logic                    out_ready       = 1'b0;
    logic                    cfg_wr_en       = 1'b0;
    logic [GAIN_W-1:0]       cfg_wr_data     = '0;
    logic                    in_ready;
    logic                    out_valid;
    logic [7:0]              tx_byte;
    logic                    last_byte;
    logic                    rejected;

    int fail_count;
    int pending;
    int cycles      = 0;
    int steady_left = 0;
    bit squeeze_req = 1'b0;

    lens_driver_command_framer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .current_first   (current_first),
        .current_second  (current_second),
        .freq_millihertz (freq_millihertz),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tx_byte         (tx_byte),
        .last_byte       (last_byte),
        .rejected        (rejected),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    ldcf_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .current_first   (current_first),
        .current_second  (current_second),
        .freq_millihertz (freq_millihertz),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tx_byte         (tx_byte),
        .last_byte       (last_byte),
        .rejected        (rejected),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** lens_driver_command_framer: FAILED **");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [15:0] pick_current();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($signed($urandom_range(0, 2)) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // One command transfer, after an optional idle gap
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [15:0] a,
                            input logic [15:0] b, input logic [31:0] f);
        int gap;
        gap = (steady_left > 0) ? 0 : pick_gap();
        if (steady_left > 0)
            steady_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        current_first   <= a;
        current_second  <= b;
        freq_millihertz <= f;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random();
        logic [OP_W-1:0] ops [4];
        logic [15:0]     a;
        logic [15:0]     b;
        logic [31:0]     f;
        ops = '{OP_SINE, OP_CUR, OP_MINMAX, OP_FREQ};
        a = pick_current();
        b = ($urandom_range(0, 7) == 0) ? a : pick_current();
        case ($urandom_range(0, 7))
            0:       f = '0;
            1:       f = '1;
            default: f = $urandom;
        endcase
        send_cmd(ops[$urandom_range(0, 3)], a, b, f);
    endtask

    // Drain all expected bytes and let the sequencer go idle
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_gain(input logic [GAIN_W-1:0] g);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Command side
    initial
    begin
        logic [GAIN_W-1:0] gains [7];
        gains    = '{24'd0, 24'hFFFFFF, 24'h200000, 24'd0, GAIN_RESET, 24'd0, 24'd0};
        gains[3] = 24'($urandom);
        gains[5] = 24'($urandom_range(0, 4095));
        gains[6] = 24'($urandom);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: refusals before sine mode, code extremes, swap, freq ends
        send_cmd(OP_MINMAX, 16'd1000, -16'sd1000, '0);
        send_cmd(OP_FREQ, '0, '0, 32'hDEADBEEF);
        send_cmd(OP_CUR, 16'h0000, '0, '0);
        send_cmd(OP_CUR, 16'h7FFF, '0, '0);
        send_cmd(OP_CUR, 16'h8000, '0, '0);
        send_cmd(OP_CUR, 16'hFFFF, '0, '0);
        send_cmd(OP_SINE, '0, '0, '0);
        send_cmd(OP_MINMAX, 16'h7FFF, 16'h8000, '0);
        send_cmd(OP_MINMAX, 16'h8000, 16'h7FFF, '0);
        send_cmd(OP_MINMAX, 16'h0123, 16'h0123, '0);
        send_cmd(OP_FREQ, '0, '0, 32'h0000_0000);
        send_cmd(OP_FREQ, '0, '0, 32'hFFFF_FFFF);
        send_cmd(OP_FREQ, '0, '0, 32'h89AB_CDEF);
        send_cmd(OP_SINE, '0, '0, '0);

        for (int p = 0; p < 7; p++)
        begin
            quiesce();
            set_gain(gains[p]);
            // saturation at full gain, exact halves at gain 2^21
            if (p == 1)
            begin
                send_cmd(OP_CUR, 16'h7FFF, '0, '0);
                send_cmd(OP_CUR, 16'h8000, '0, '0);
            end
            if (p == 2)
            begin
                send_cmd(OP_CUR, 16'h0001, '0, '0);
                send_cmd(OP_CUR, 16'hFFFF, '0, '0);
                send_cmd(OP_CUR, 16'h0003, '0, '0);
                send_cmd(OP_CUR, 16'hFFFD, '0, '0);
            end
            if (p == 1 || p == 4)
                squeeze_req = 1'b1;
            steady_left = $urandom_range(0, 1) ? 8 : 0;
            repeat (ITEMS_PER_PHASE) send_random();
        end

        quiesce();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("** lens_driver_command_framer: PASSED **");
        else
            $display("** lens_driver_command_framer: FAILED **");
        $finish;
    end

    // Byte side: random stalls, ready bursts, and a long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

endmodule
